// ===== hdl/tal_pkg.sv =====
// ----------------------------------------------------------------------------
// tal_pkg
// Shared types and constants of the three-axis attitude lock controller.
// ----------------------------------------------------------------------------
package tal_pkg;

  // configuration register file
  localparam int NUM_REGS = 7;
  localparam int REG_W    = 48;
  localparam int IDX_W    = 3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_P_GAINS   = 3'd0;
  localparam logic [IDX_W-1:0] REG_I_GAINS   = 3'd1;
  localparam logic [IDX_W-1:0] REG_D_GAINS   = 3'd2;
  localparam logic [IDX_W-1:0] REG_INT_LIMS  = 3'd3;
  localparam logic [IDX_W-1:0] REG_DEADBANDS = 3'd4;
  localparam logic [IDX_W-1:0] REG_CENTERS   = 3'd5;
  localparam logic [IDX_W-1:0] REG_LOCK_GAIN = 3'd6;

  // default loop period in milliseconds
  localparam int DEF_LOOP_PERIOD_MS = 2;

  // angle step divisor (ms per second) and its rounding half
  localparam int DIVISOR  = 1000;
  localparam int HALF_DIV = 500;

  // input word
  typedef struct packed {
    logic        [2:0]  axis_mask;
    logic        [15:0] roll_stick;
    logic        [15:0] pitch_stick;
    logic        [15:0] yaw_stick;
    logic signed [15:0] roll_rate;
    logic signed [15:0] pitch_rate;
    logic signed [15:0] yaw_rate;
    logic signed [31:0] roll_correction_in;
    logic signed [31:0] pitch_correction_in;
    logic signed [31:0] yaw_correction_in;
  } in_word_t;

  // output word
  typedef struct packed {
    logic signed [31:0] roll_correction_out;
    logic signed [31:0] pitch_correction_out;
    logic signed [31:0] yaw_correction_out;
    logic        [2:0]  locked_flags;
  } out_word_t;

  // pick the 16-bit field of one axis out of a packed register
  function automatic logic [15:0] field16(input logic [REG_W-1:0] r, input logic [1:0] ax);
    logic [15:0] f;
    unique case (ax)
      2'd0:    f = r[15:0];
      2'd1:    f = r[31:16];
      default: f = r[47:32];
    endcase
    return f;
  endfunction

endpackage

// ===== hdl/three_axis_attitude_lock_pid.sv =====
// ----------------------------------------------------------------------------
// three_axis_attitude_lock_pid
// Heading hold PID for roll, pitch and yaw with integral clamp and
// saturating Q16.16 correction outputs.
// ----------------------------------------------------------------------------
// One word is taken at a time; the axes are worked through in turn on one
// shared bit-serial datapath. A disabled axis, or one whose stick is outside
// its deadband, is skipped in S_START. A locked axis runs the radix-2
// divider for the angle step over the NUM_W bits of its dividend (32 at a
// 2 ms loop period), then the angle, error and integral updates, the two
// shift-add multipliers with their rounding steps, and the final sum. After
// the last axis the sequencer waits in S_OUT until the output register is
// free. The result sits in an output register, so a new word is accepted
// while the previous result still waits.
module three_axis_attitude_lock_pid
  import tal_pkg::*;
#(
  parameter int LOOP_PERIOD_MS = DEF_LOOP_PERIOD_MS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_word_t             in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_word_t            out_word_o,
  input  logic                 cfg_we_i,
  input  logic [IDX_W-1:0]     cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_data_i
);

  // widths derived from the loop period
  localparam int MR_W  = 17 + $clog2(LOOP_PERIOD_MS + 1);
  localparam int NUM_W = MR_W + 13;
  localparam int SUM_W = (NUM_W + 2 > 34) ? NUM_W + 2 : 34;
  localparam int CNT_W = $clog2(NUM_W);
  localparam int ACC_W = 61;
  localparam int PID_W = 45;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_DIV, S_ANG, S_ERR, S_INT,
    S_MUL1, S_RND1, S_MUL2, S_RND2, S_SUM, S_OUT
  } state_e;

  state_e                    state_q;
  logic [REG_W-1:0]          cfg_q [NUM_REGS];
  in_word_t                  in_q;
  logic [1:0]                ax_q;
  logic                      locked_q [3];
  logic signed [31:0]        angle_q  [3];
  logic signed [31:0]        prev_q   [3];
  logic signed [31:0]        integ_q  [3];
  logic signed [31:0]        res_q    [3];
  logic [CNT_W-1:0]          cnt_q;
  logic [NUM_W-1:0]          num_q;
  logic [9:0]                rem_q;
  logic                      neg_q;
  logic signed [31:0]        err_q;
  logic signed [32:0]        delta_q;
  logic signed [PID_W-1:0]   pid_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [PID_W-1:0]   term_q;
  out_word_t                 out_q;
  logic                      out_valid_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_q[i] <= '0;
    end else if (cfg_we_i && (int'(cfg_idx_i) < NUM_REGS)) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // per-axis operand selection
  logic [15:0]        stick_s, g_p, g_i, g_d, g_lim, g_db, g_ctr, g_lock;
  logic signed [15:0] rate_s;
  logic signed [31:0] corr_s;
  always_comb begin
    unique case (ax_q)
      2'd0: begin
        stick_s = in_q.roll_stick;  rate_s = in_q.roll_rate;  corr_s = in_q.roll_correction_in;
      end
      2'd1: begin
        stick_s = in_q.pitch_stick; rate_s = in_q.pitch_rate; corr_s = in_q.pitch_correction_in;
      end
      default: begin
        stick_s = in_q.yaw_stick;   rate_s = in_q.yaw_rate;   corr_s = in_q.yaw_correction_in;
      end
    endcase
    g_p    = field16(cfg_q[REG_P_GAINS],   ax_q);
    g_i    = field16(cfg_q[REG_I_GAINS],   ax_q);
    g_d    = field16(cfg_q[REG_D_GAINS],   ax_q);
    g_lim  = field16(cfg_q[REG_INT_LIMS],  ax_q);
    g_db   = field16(cfg_q[REG_DEADBANDS], ax_q);
    g_ctr  = field16(cfg_q[REG_CENTERS],   ax_q);
    g_lock = field16(cfg_q[REG_LOCK_GAIN], ax_q);
  end

  // deadband test and divider load
  logic [16:0]      dev, abs_dev, rate_x, mag_rate;
  logic             in_band;
  logic [MR_W-1:0]  rate_prod;
  logic [NUM_W-1:0] num_init;
  always_comb begin
    dev      = {1'b0, stick_s} - {1'b0, g_ctr};
    abs_dev  = dev[16] ? (17'd0 - dev) : dev;
    in_band  = abs_dev <= {1'b0, g_db};
    rate_x   = {rate_s[15], rate_s};
    mag_rate = rate_s[15] ? (17'd0 - rate_x) : rate_x;
    rate_prod = MR_W'(mag_rate) * MR_W'(LOOP_PERIOD_MS);
    num_init = NUM_W'({rate_prod, 12'd0}) + NUM_W'(HALF_DIV);
  end

  // one restoring division step
  logic [10:0] rem2;
  logic        div_ge;
  always_comb begin
    rem2   = {rem_q, num_q[NUM_W-1]};
    div_ge = rem2 >= 11'(DIVISOR);
  end

  // angle sum update with saturation
  logic signed [SUM_W-1:0] step_s, ang_sum;
  logic                    ang_ovf;
  always_comb begin
    step_s  = neg_q ? (SUM_W'(0) - SUM_W'(num_q)) : SUM_W'(num_q);
    ang_sum = {{(SUM_W-32){angle_q[ax_q][31]}}, angle_q[ax_q]} + step_s;
    ang_ovf = !((&ang_sum[SUM_W-1:31]) || !(|ang_sum[SUM_W-1:31]));
  end

  // integral with clamp
  logic signed [33:0] isum, ilim, iclamp;
  logic               i_ovf;
  always_comb begin
    isum = {{2{err_q[31]}}, err_q} + {{2{integ_q[ax_q][31]}}, integ_q[ax_q]};
    ilim = {2'b00, g_lim, 16'd0};
    if (isum > ilim)             iclamp = ilim;
    else if (isum < -ilim)       iclamp = -ilim;
    else                         iclamp = isum;
    i_ovf = !((&iclamp[33:31]) || !(|iclamp[33:31]));
  end

  // shift-add step of both multipliers, rounding and final sum
  logic [3:0]              bit_sel;
  logic signed [ACC_W-1:0] mul1_d, mul2_d, rnd_v;
  logic signed [45:0]      fin_sum;
  logic                    fin_ovf;
  always_comb begin
    bit_sel = cnt_q[3:0];
    mul1_d  = (acc_q <<< 1)
            + (g_p[bit_sel] ? {{(ACC_W-32){err_q[31]}}, err_q} : '0)
            + (g_i[bit_sel] ? {{(ACC_W-32){integ_q[ax_q][31]}}, integ_q[ax_q]} : '0)
            + (g_d[bit_sel] ? {{(ACC_W-33){delta_q[32]}}, delta_q} : '0);
    mul2_d  = (acc_q <<< 1)
            + (g_lock[bit_sel] ? {{(ACC_W-PID_W){pid_q[PID_W-1]}}, pid_q} : '0);
    // ties away from zero: add half, less one when negative
    if (state_q == S_RND1) begin
      rnd_v = (acc_q + (acc_q[ACC_W-1] ? ACC_W'(127) : ACC_W'(128))) >>> 8;
    end else begin
      rnd_v = (acc_q + (acc_q[ACC_W-1] ? ACC_W'(32767) : ACC_W'(32768))) >>> 16;
    end
    fin_sum = {{14{corr_s[31]}}, corr_s} + {term_q[PID_W-1], term_q};
    fin_ovf = !((&fin_sum[45:31]) || !(|fin_sum[45:31]));
  end

  // sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_q        <= '0;
      ax_q        <= '0;
      cnt_q       <= '0;
      num_q       <= '0;
      rem_q       <= '0;
      neg_q       <= 1'b0;
      err_q       <= '0;
      delta_q     <= '0;
      pid_q       <= '0;
      acc_q       <= '0;
      term_q      <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        locked_q[a] <= 1'b0;
        angle_q[a]  <= '0;
        prev_q[a]   <= '0;
        integ_q[a]  <= '0;
        res_q[a]    <= '0;
      end
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            in_q    <= in_word_i;
            ax_q    <= '0;
            state_q <= S_START;
          end
        end
        S_START: begin
          res_q[ax_q] <= corr_s;
          if (!in_q.axis_mask[ax_q]) begin
            state_q <= (ax_q == 2'd2) ? S_OUT : S_START;
            ax_q    <= (ax_q == 2'd2) ? ax_q : ax_q + 2'd1;
          end else if (!in_band) begin
            locked_q[ax_q] <= 1'b0;
            state_q <= (ax_q == 2'd2) ? S_OUT : S_START;
            ax_q    <= (ax_q == 2'd2) ? ax_q : ax_q + 2'd1;
          end else begin
            if (!locked_q[ax_q]) begin
              angle_q[ax_q] <= '0;
              prev_q[ax_q]  <= '0;
              integ_q[ax_q] <= '0;
            end
            locked_q[ax_q] <= 1'b1;
            num_q   <= num_init;
            rem_q   <= '0;
            neg_q   <= rate_s[15];
            cnt_q   <= CNT_W'(NUM_W - 1);
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q <= div_ge ? 10'(rem2 - 11'(DIVISOR)) : rem2[9:0];
          num_q <= {num_q[NUM_W-2:0], div_ge};
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == '0) state_q <= S_ANG;
        end
        S_ANG: begin
          angle_q[ax_q] <= ang_ovf ? (ang_sum[SUM_W-1] ? 32'sh80000000 : 32'sh7fffffff)
                                   : ang_sum[31:0];
          state_q <= S_ERR;
        end
        S_ERR: begin
          err_q   <= (angle_q[ax_q] == 32'sh80000000) ? 32'sh7fffffff : -angle_q[ax_q];
          state_q <= S_INT;
        end
        S_INT: begin
          delta_q       <= {err_q[31], err_q} - {prev_q[ax_q][31], prev_q[ax_q]};
          integ_q[ax_q] <= i_ovf ? (iclamp[33] ? 32'sh80000000 : 32'sh7fffffff)
                                 : iclamp[31:0];
          prev_q[ax_q]  <= err_q;
          acc_q         <= '0;
          cnt_q         <= CNT_W'(15);
          state_q       <= S_MUL1;
        end
        S_MUL1: begin
          acc_q <= mul1_d;
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == '0) state_q <= S_RND1;
        end
        S_RND1: begin
          pid_q   <= rnd_v[PID_W-1:0];
          acc_q   <= '0;
          cnt_q   <= CNT_W'(15);
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          acc_q <= mul2_d;
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == '0) state_q <= S_RND2;
        end
        S_RND2: begin
          term_q  <= rnd_v[PID_W-1:0];
          state_q <= S_SUM;
        end
        S_SUM: begin
          res_q[ax_q] <= fin_ovf ? (fin_sum[45] ? 32'sh80000000 : 32'sh7fffffff)
                                 : fin_sum[31:0];
          state_q <= (ax_q == 2'd2) ? S_OUT : S_START;
          ax_q    <= (ax_q == 2'd2) ? ax_q : ax_q + 2'd1;
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.roll_correction_out  <= res_q[0];
            out_q.pitch_correction_out <= res_q[1];
            out_q.yaw_correction_out   <= res_q[2];
            out_q.locked_flags         <= {locked_q[2], locked_q[1], locked_q[0]};
            out_valid_q                <= 1'b1;
            state_q                    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef ASSERT_OFF
  // a new result only appears from the output state
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT)) else $error("result without sequencing");

  // an accepted word always starts the axis walk at roll
  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_START && ax_q == 2'd0))
    else $error("accepted word did not start at roll");

  // divider remainder stays below the divisor
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < 10'(DIVISOR))) else $error("divider remainder out of range");

  // axis counter never leaves the three axes
  a_axis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ax_q != 2'd3) else $error("axis counter out of range");
`endif

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives random and directed control ticks into the attitude lock controller
// and checks every output word against a cycle-free predictor, under random
// idling on both channels, across several register settings.
// ----------------------------------------------------------------------------
module testbench
  import tal_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 250;
  localparam int LONG_HOLD      = 500;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;
  logic             cfg_we_i = 1'b0;
  logic [IDX_W-1:0] cfg_idx_i = '0;
  logic [REG_W-1:0] cfg_data_i = '0;

  three_axis_attitude_lock_pid dut (.*);

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // predictor state
  logic [REG_W-1:0] gain_regs [NUM_REGS];
  logic             lock_st [3];
  longint           angle_acc [3];
  longint           last_err [3];
  longint           integ_acc [3];

  in_word_t  pending_words [$];
  out_word_t expected_words [$];
  bit        in_taken = 1'b0;
  bit        quiet = 1'b0;
  int        hold_asked = 0;
  int        hold_done = 0;
  int        errors = 0;
  int        idle_cycles = 0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // round to nearest, ties away from zero
  function automatic longint shift_round(longint v, int s);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (s - 1))) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint div_round(longint v, longint d);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + d / 2) / d;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint fld(int r, int ax);
    return longint'(gain_regs[r][16*ax +: 16]);
  endfunction

  // heading hold update of all three axes for one word
  function automatic out_word_t hold_correction(in_word_t w);
    out_word_t   o;
    logic [15:0] stick [3];
    longint      rate [3];
    longint      corr [3];
    longint      dev, step, err, delta, lim, integ, pid, term;
    bit          in_band;
    stick = '{w.roll_stick, w.pitch_stick, w.yaw_stick};
    rate  = '{longint'(w.roll_rate), longint'(w.pitch_rate), longint'(w.yaw_rate)};
    corr  = '{longint'(w.roll_correction_in), longint'(w.pitch_correction_in),
              longint'(w.yaw_correction_in)};
    o = '0;
    for (int a = 0; a < 3; a++) begin
      if (w.axis_mask[a]) begin
        dev = longint'(stick[a]) - fld(REG_CENTERS, a);
        if (dev < 0) dev = -dev;
        in_band = (dev <= fld(REG_DEADBANDS, a));
        if (!lock_st[a] && in_band) begin
          lock_st[a] = 1'b1;
          angle_acc[a] = 0;
          last_err[a] = 0;
          integ_acc[a] = 0;
        end
        if (lock_st[a]) begin
          if (!in_band) begin
            lock_st[a] = 1'b0;
          end else begin
            step = div_round(rate[a] * DEF_LOOP_PERIOD_MS * 4096, 1000);
            angle_acc[a] = sat32(angle_acc[a] + step);
            err = sat32(-angle_acc[a]);
            delta = err - last_err[a];
            lim = fld(REG_INT_LIMS, a) <<< 16;
            integ = integ_acc[a] + err;
            if (integ > lim) integ = lim;
            else if (integ < -lim) integ = -lim;
            integ_acc[a] = sat32(integ);
            last_err[a] = err;
            pid = err * fld(REG_P_GAINS, a) + integ_acc[a] * fld(REG_I_GAINS, a)
                + delta * fld(REG_D_GAINS, a);
            pid = shift_round(pid, 8);
            term = shift_round(pid * fld(REG_LOCK_GAIN, a), 16);
            corr[a] = sat32(corr[a] + term);
          end
        end
      end
      o.locked_flags[a] = lock_st[a];
    end
    o.roll_correction_out  = corr[0][31:0];
    o.pitch_correction_out = corr[1][31:0];
    o.yaw_correction_out   = corr[2][31:0];
    return o;
  endfunction

  // prediction on accept, checking of results, watchdog
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        lock_st[a] = 1'b0;
        angle_acc[a] = 0;
        last_err[a] = 0;
        integ_acc[a] = 0;
      end
      for (int r = 0; r < NUM_REGS; r++) gain_regs[r] = '0;
    end else begin
      in_taken <= in_valid_i && !in_stall_o;
      if (cfg_we_i && cfg_idx_i < NUM_REGS) gain_regs[cfg_idx_i] = cfg_data_i;
      if (in_valid_i && !in_stall_o) expected_words.push_back(hold_correction(in_word_i));
      if (out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word %h", $realtime, out_word_o);
          errors++;
        end else begin
          out_word_t e;
          e = expected_words.pop_front();
          if (e.roll_correction_out !== out_word_o.roll_correction_out) begin
            $display("%0t: roll exp %h got %h", $realtime,
                     e.roll_correction_out, out_word_o.roll_correction_out);
            errors++;
          end
          if (e.pitch_correction_out !== out_word_o.pitch_correction_out) begin
            $display("%0t: pitch exp %h got %h", $realtime,
                     e.pitch_correction_out, out_word_o.pitch_correction_out);
            errors++;
          end
          if (e.yaw_correction_out !== out_word_o.yaw_correction_out) begin
            $display("%0t: yaw exp %h got %h", $realtime,
                     e.yaw_correction_out, out_word_o.yaw_correction_out);
            errors++;
          end
          if (e.locked_flags !== out_word_o.locked_flags) begin
            $display("%0t: flags exp %b got %b", $realtime,
                     e.locked_flags, out_word_o.locked_flags);
            errors++;
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // sender: offers queued words with random gaps
  int send_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_taken) begin
        in_valid_i <= 1'b1;
      end else if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_words.size() > 0) begin
        if (!quiet && $urandom_range(0, 5) == 0) begin
          in_valid_i <= 1'b0;
          send_gap <= $urandom_range(0, 16);
        end else begin
          in_word_i <= pending_words.pop_front();
          in_valid_i <= 1'b1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stall bursts and the occasional long hold-off
  int stall_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (hold_done != hold_asked) begin
        out_stall_i <= 1'b1;
        stall_left <= LONG_HOLD - 1;
        hold_done <= hold_asked;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        stall_left <= $urandom_range(0, 16);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid_i || expected_words.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_stick(int ax);
    longint c, d, v;
    c = fld(REG_CENTERS, ax);
    d = fld(REG_DEADBANDS, ax);
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    v = $urandom_range(0, 1) ? c + $urandom_range(0, int'(d)) : c - $urandom_range(0, int'(d));
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  function automatic logic [15:0] pick_rate();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 64));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_corr();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    w.axis_mask = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'b111;
    w.roll_stick = pick_stick(0);
    w.pitch_stick = pick_stick(1);
    w.yaw_stick = pick_stick(2);
    w.roll_rate = pick_rate();
    w.pitch_rate = pick_rate();
    w.yaw_rate = pick_rate();
    w.roll_correction_in = pick_corr();
    w.pitch_correction_in = pick_corr();
    w.yaw_correction_in = pick_corr();
    return w;
  endfunction

  // per-field register value: 0 zeros, 1 all ones, 2 modest, 3 full random
  function automatic logic [REG_W-1:0] reg_value(int style, int hi);
    logic [REG_W-1:0] v;
    for (int a = 0; a < 3; a++) begin
      case (style)
        0: v[16*a +: 16] = 16'h0000;
        1: v[16*a +: 16] = 16'hffff;
        2: v[16*a +: 16] = 16'($urandom_range(0, hi));
        default: v[16*a +: 16] = 16'($urandom);
      endcase
    end
    return v;
  endfunction

  // stimulus
  initial begin
    in_word_t w;
    int style;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: disabled axes, lock, extremes of rate and correction, unlock
    write_reg(REG_P_GAINS, reg_value(2, 1024));
    write_reg(REG_I_GAINS, reg_value(2, 256));
    write_reg(REG_D_GAINS, reg_value(2, 512));
    write_reg(REG_INT_LIMS, {16'd1, 16'd2, 16'd3});
    write_reg(REG_DEADBANDS, {16'd100, 16'd0, 16'd65535});
    write_reg(REG_CENTERS, {16'd32768, 16'd0, 16'd65535});
    write_reg(REG_LOCK_GAIN, {16'hffff, 16'h8000, 16'h0001});
    write_reg(3'd7, '1);
    w = '0;
    w.roll_stick = 16'd65535;
    w.yaw_stick = 16'd32768;
    pending_words.push_back(w);
    for (int i = 0; i < 16; i++) begin
      w.axis_mask = 3'b111;
      w.roll_stick = (i == 10) ? 16'd0 : 16'd65535;
      w.pitch_stick = (i == 12) ? 16'd1 : 16'd0;
      w.yaw_stick = (i[0]) ? 16'd32668 : 16'd32868;
      w.roll_rate = (i < 8) ? 16'sh7fff : 16'sh8000;
      w.pitch_rate = (i < 8) ? 16'sh8000 : 16'sh7fff;
      w.yaw_rate = 16'($urandom);
      w.roll_correction_in = (i[1]) ? 32'h7fffffff : 32'h80000000;
      w.pitch_correction_in = (i[1]) ? 32'h80000000 : 32'h7fffffff;
      w.yaw_correction_in = $urandom;
      if (i == 14) w.axis_mask = 3'b000;
      pending_words.push_back(w);
    end
    wait_drained();

    // random phases over several register settings
    for (int ph = 0; ph < 8; ph++) begin
      style = (ph == 0) ? 1 : (ph == 1) ? 0 : (ph == 2) ? 3 : 2;
      write_reg(REG_P_GAINS, reg_value(style, 2048));
      write_reg(REG_I_GAINS, reg_value(style, 512));
      write_reg(REG_D_GAINS, reg_value(style, 2048));
      write_reg(REG_INT_LIMS, reg_value(style, 200));
      write_reg(REG_DEADBANDS, reg_value((ph == 1) ? 2 : style, 4000));
      write_reg(REG_CENTERS, reg_value(3, 0));
      write_reg(REG_LOCK_GAIN, reg_value(style, 65535));
      write_reg(3'd7, reg_value(3, 0));
      if (ph == 7) quiet = 1'b1;
      for (int i = 0; i < 85; i++) pending_words.push_back(random_word());
      if (ph == 3) begin
        repeat (20) @(posedge clk_i);
        hold_asked = hold_asked + 1;
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
